// ===== rtl/fpc_pkg.sv =====
package fpc_pkg;

	localparam int PlaneCount   = 6;
	localparam int FractionBits = 16;
	localparam int QW           = 32;
	// rounded product of two q values, and the sum of up to four of them
	localparam int ProdW        = 2*QW - FractionBits;
	localparam int SumW         = ProdW + 4;

	typedef logic signed [QW-1:0] q_t;

	typedef enum logic [2:0] {
		KIND_VIEW   = 3'd0,
		KIND_PROJ   = 3'd1,
		KIND_BUILD  = 3'd2,
		KIND_POINT  = 3'd3,
		KIND_SPHERE = 3'd4
	} kind_t;

	localparam logic [2:0] NoPlane = 3'd6;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] row_index;
		q_t         value_a;
		q_t         value_b;
		q_t         value_c;
		q_t         value_d;
	} req_t;

	typedef struct packed {
		logic       visible;
		logic [2:0] culling_plane;
	} rsp_t;

	// rounded product, ties toward plus infinity, not saturated
	function automatic logic signed [ProdW-1:0] qmul_round(input logic signed [2*QW-1:0] p);
		logic signed [2*QW:0] r;
		begin
			r = {p[2*QW-1], p} + ((2*QW+1)'(1) <<< (FractionBits - 1));
			qmul_round = (ProdW)'(r >>> FractionBits);
		end
	endfunction

	function automatic q_t sat32(input logic signed [SumW-1:0] v);
		begin
			if (v > (SumW)'(signed'({1'b0, {(QW-1){1'b1}}})))
				sat32 = {1'b0, {(QW-1){1'b1}}};
			else if (v < -(SumW)'(signed'({1'b0, 1'b1, {(QW-1){1'b0}}})))
				sat32 = {1'b1, {(QW-1){1'b0}}};
			else
				sat32 = v[QW-1:0];
		end
	endfunction

endpackage

// ===== rtl/fpc_if.sv =====
interface fpc_req_if;
	import fpc_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fpc_rsp_if;
	import fpc_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fpc_mac.sv =====
// three multipliers, rounded products registered, sum of three products plus an addend
module fpc_mac import fpc_pkg::*; (
	input  logic                   clk,
	input  q_t                     x0,
	input  q_t                     y0,
	input  q_t                     x1,
	input  q_t                     y1,
	input  q_t                     x2,
	input  q_t                     y2,
	input  logic signed [QW+1:0]   addend,
	output logic signed [SumW-1:0] sum
);
	logic signed [ProdW-1:0] p0_s1, p1_s1, p2_s1;

	always_ff @(posedge clk) begin
		p0_s1 <= qmul_round(x0 * y0);
		p1_s1 <= qmul_round(x1 * y1);
		p2_s1 <= qmul_round(x2 * y2);
	end

	assign sum = (SumW)'(p0_s1) + (SumW)'(p1_s1) + (SumW)'(p2_s1) + (SumW)'(addend);
endmodule

// ===== rtl/frustum_plane_cull_unit.sv =====
// channel | dir | payload                                   | accepted when
// req     | in  | kind, row_index, value_a..value_d          | valid && ready
// rsp     | out | visible, culling_plane                     | valid && ready
//
// a load is written as it is taken; a point or sphere test sends each plane through the
// shared three-multiplier unit (issue, then evaluate the registered products), up to
// all six planes, fewer when an early plane culls; the result shows in the cycle after that
// a build runs 16 elements through ST_MUL_A, ST_MUL_B and ST_ACC (two passes of the
// unit each), then ST_EXTRACT; the sequencer owns the unit, so one request at a time
// reset clears all matrices and planes at once (flip-flop storage)
// the result register holds while rsp is stalled; no request is taken until it drains
module frustum_plane_cull_unit import fpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	fpc_req_if.sink   req,
	fpc_rsp_if.source rsp
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_A, ST_MUL_B, ST_ACC, ST_EXTRACT, ST_TEST_ISSUE, ST_TEST_EVAL, ST_OUT
	} state_t;

	state_t state_q;
	q_t view_q [16];
	q_t proj_q [16];
	q_t plane_q [PlaneCount*4];
	q_t vp_q [16];
	q_t pt_x_q, pt_y_q, pt_z_q, radius_q;
	logic [3:0] elem_q;
	logic [2:0] plane_idx_q;
	logic signed [SumW-1:0] part_q;
	logic       vis_q;
	logic [2:0] cull_q;

	// shared unit operand selection
	q_t x0, y0, x1, y1, x2, y2;
	logic signed [QW+1:0] addend;
	logic signed [SumW-1:0] sum;
	logic [1:0] ei, ej;
	logic [4:0] pb;

	assign ei = elem_q[3:2];
	assign ej = elem_q[1:0];
	assign pb = 5'(plane_idx_q) << 2;

	always_comb begin
		x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
		addend = '0;
		case (state_q)
			ST_MUL_A: begin
				// k = 0, 1, 2
				x0 = view_q[{ei, 2'd0}]; y0 = proj_q[{2'd0, ej}];
				x1 = view_q[{ei, 2'd1}]; y1 = proj_q[{2'd1, ej}];
				x2 = view_q[{ei, 2'd2}]; y2 = proj_q[{2'd2, ej}];
			end
			ST_MUL_B: begin
				// k = 3
				x0 = view_q[{ei, 2'd3}]; y0 = proj_q[{2'd3, ej}];
			end
			ST_TEST_ISSUE: begin
				x0 = plane_q[pb];      y0 = pt_x_q;
				x1 = plane_q[pb + 5'd1]; y1 = pt_y_q;
				x2 = plane_q[pb + 5'd2]; y2 = pt_z_q;
			end
			default: ;
		endcase
		if (state_q == ST_TEST_EVAL)
			addend = (QW+2)'(plane_q[pb + 5'd3]) + (QW+2)'(radius_q);
	end

	fpc_mac u_mac (
		.clk(clk), .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2),
		.addend(addend), .sum(sum)
	);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = (state_q == ST_OUT);
	assign rsp.payload.visible       = vis_q;
	assign rsp.payload.culling_plane = cull_q;

	logic signed [SumW-1:0] c1, c2, c3, c4;
	logic [1:0] xr;
	assign xr = elem_q[1:0];
	assign c1 = (SumW)'(vp_q[{xr, 2'd0}]);
	assign c2 = (SumW)'(vp_q[{xr, 2'd1}]);
	assign c3 = (SumW)'(vp_q[{xr, 2'd2}]);
	assign c4 = (SumW)'(vp_q[{xr, 2'd3}]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 16; i++) begin
				view_q[i] <= '0;
				proj_q[i] <= '0;
				vp_q[i]   <= '0;
			end
			for (int i = 0; i < PlaneCount*4; i++)
				plane_q[i] <= '0;
			elem_q      <= '0;
			plane_idx_q <= '0;
			part_q      <= '0;
			vis_q       <= 1'b0;
			cull_q      <= NoPlane;
			pt_x_q <= '0; pt_y_q <= '0; pt_z_q <= '0; radius_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						elem_q      <= '0;
						plane_idx_q <= '0;
						pt_x_q   <= req.payload.value_a;
						pt_y_q   <= req.payload.value_b;
						pt_z_q   <= req.payload.value_c;
						radius_q <= (req.payload.kind == KIND_SPHERE) ? req.payload.value_d : '0;
						case (req.payload.kind)
							KIND_VIEW: begin
								view_q[{req.payload.row_index, 2'd0}] <= req.payload.value_a;
								view_q[{req.payload.row_index, 2'd1}] <= req.payload.value_b;
								view_q[{req.payload.row_index, 2'd2}] <= req.payload.value_c;
								view_q[{req.payload.row_index, 2'd3}] <= req.payload.value_d;
							end
							KIND_PROJ: begin
								proj_q[{req.payload.row_index, 2'd0}] <= req.payload.value_a;
								proj_q[{req.payload.row_index, 2'd1}] <= req.payload.value_b;
								proj_q[{req.payload.row_index, 2'd2}] <= req.payload.value_c;
								proj_q[{req.payload.row_index, 2'd3}] <= req.payload.value_d;
							end
							KIND_BUILD:  state_q <= ST_MUL_A;
							KIND_POINT, KIND_SPHERE: state_q <= ST_TEST_ISSUE;
							default: ;
						endcase
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: begin
					// sum here is the first three products
					part_q  <= sum;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					vp_q[elem_q] <= sat32(part_q + sum);
					elem_q <= elem_q + 4'd1;
					if (elem_q == 4'd15) begin
						elem_q  <= '0;
						state_q <= ST_EXTRACT;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_EXTRACT: begin
					// one vp row per cycle becomes coefficient xr of all six planes
					plane_q[5'd0  + 5'(xr)] <= sat32(c4 + c1);
					plane_q[5'd4  + 5'(xr)] <= sat32(c4 - c1);
					plane_q[5'd8  + 5'(xr)] <= sat32(c4 - c2);
					plane_q[5'd12 + 5'(xr)] <= sat32(c4 + c2);
					plane_q[5'd16 + 5'(xr)] <= sat32(c3);
					plane_q[5'd20 + 5'(xr)] <= sat32(c4 - c3);
					elem_q <= elem_q + 4'd1;
					if (xr == 2'd3)
						state_q <= ST_IDLE;
				end
				ST_TEST_ISSUE: state_q <= ST_TEST_EVAL;
				ST_TEST_EVAL: begin
					if (sum[SumW-1]) begin
						vis_q   <= 1'b0;
						cull_q  <= plane_idx_q;
						state_q <= ST_OUT;
					end else if (plane_idx_q == 3'(PlaneCount - 1)) begin
						vis_q   <= 1'b1;
						cull_q  <= NoPlane;
						state_q <= ST_OUT;
					end else begin
						plane_idx_q <= plane_idx_q + 3'd1;
						state_q     <= ST_TEST_ISSUE;
					end
				end
				ST_OUT: begin
					if (rsp.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/fpc_checker.sv =====
module fpc_checker import fpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       visible,
	input logic [2:0] culling_plane
);
	// a result never overlaps request intake
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_valid && req_ready)) else $error("rsp valid while taking requests");

	// visible iff no failing plane
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (visible == (culling_plane == NoPlane))) else $error("bad result code");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (culling_plane <= NoPlane)) else $error("plane out of range");

	// a result is held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(culling_plane))
		else $error("result dropped while stalled");

	// a request is never taken while a result is valid
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && rsp_valid) |-> 1'b0) else $error("overlap");
endmodule

bind frustum_plane_cull_unit fpc_checker u_fpc_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.visible(rsp.payload.visible), .culling_plane(rsp.payload.culling_plane)
);

// ===== test/tb_fpc_if.sv =====
`timescale 1ns / 1ps

// testbench copies of the channel interfaces are not needed: the rtl interfaces are used
// this file carries a small helper package for request construction
package tb_fpc_pkg;
	import fpc_pkg::*;

	function automatic req_t make_req(input logic [2:0] kind, input logic [1:0] row,
			input q_t a, input q_t b, input q_t c, input q_t d);
		req_t r;
		r.kind = kind;
		r.row_index = row;
		r.value_a = a;
		r.value_b = b;
		r.value_c = c;
		r.value_d = d;
		return r;
	endfunction
endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fpc_pkg::*;
	import tb_fpc_pkg::*;

	localparam int StallLimit = 4000;

	logic clk;
	logic arst_n;

	fpc_req_if req_ch ();
	fpc_rsp_if rsp_ch ();

	frustum_plane_cull_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// requests waiting to be driven, filled by the stimulus block
	req_t pending_reqs[$];
	// verdicts predicted for accepted tests, oldest first
	rsp_t expected_verdicts[$];

	// shadow of the block's matrices and planes
	q_t view_m[16];
	q_t proj_m[16];
	q_t planes[24];

	int  fail_count;
	bit  stim_done;
	int  idle_cycles;
	// long receiver hold-off, armed by the stimulus block
	int  hold_off_cycles;

	// rounded product, ties toward plus infinity
	function automatic longint round_mul(input q_t x, input q_t y);
		longint p;
		p = longint'(x) * longint'(y) + (longint'(1) <<< (FractionBits - 1));
		return p >>> FractionBits;
	endfunction

	function automatic q_t clamp_q(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return q_t'(v);
	endfunction

	// view * projection, then the six column combinations
	task automatic rebuild_planes();
		q_t     vp[16];
		longint acc;
		longint c1, c2, c3, c4;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += round_mul(view_m[i*4+k], proj_m[k*4+j]);
				vp[i*4+j] = clamp_q(acc);
			end
		for (int i = 0; i < 4; i++) begin
			c1 = vp[i*4+0];
			c2 = vp[i*4+1];
			c3 = vp[i*4+2];
			c4 = vp[i*4+3];
			planes[0*4+i] = clamp_q(c4 + c1);
			planes[1*4+i] = clamp_q(c4 - c1);
			planes[2*4+i] = clamp_q(c4 - c2);
			planes[3*4+i] = clamp_q(c4 + c2);
			planes[4*4+i] = clamp_q(c3);
			planes[5*4+i] = clamp_q(c4 - c3);
		end
	endtask

	// apply one accepted request to the shadow state; tests queue a verdict
	task automatic apply_request(input req_t r);
		longint radius;
		longint distance;
		rsp_t   v;
		case (r.kind)
			KIND_VIEW, KIND_PROJ: begin
				for (int c = 0; c < 4; c++) begin
					q_t e;
					e = (c == 0) ? r.value_a : (c == 1) ? r.value_b :
						(c == 2) ? r.value_c : r.value_d;
					if (r.kind == KIND_VIEW)
						view_m[r.row_index*4+c] = e;
					else
						proj_m[r.row_index*4+c] = e;
				end
			end
			KIND_BUILD: rebuild_planes();
			KIND_POINT, KIND_SPHERE: begin
				radius = (r.kind == KIND_SPHERE) ? longint'(r.value_d) : 0;
				v.visible = 1'b1;
				v.culling_plane = NoPlane;
				for (int p = 0; p < PlaneCount; p++) begin
					distance = round_mul(planes[p*4+0], r.value_a)
						+ round_mul(planes[p*4+1], r.value_b)
						+ round_mul(planes[p*4+2], r.value_c)
						+ longint'(planes[p*4+3]);
					if (distance + radius < 0) begin
						v.visible = 1'b0;
						v.culling_plane = 3'(p);
						break;
					end
				end
				expected_verdicts.push_back(v);
			end
			default: ; // unused kinds leave everything alone
		endcase
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// reset once at start, then released
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver: random gap before each request, valid held until taken
	int gap_left;
	initial begin
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		gap_left = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				apply_request(req_ch.payload);
				void'(pending_reqs.pop_front());
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.payload <= pending_reqs[0];
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random ready pattern, plus the long hold-off when armed
	int rsp_wait;
	initial begin
		rsp_ch.ready = 1'b0;
		rsp_wait = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected verdict visible=%0b plane=%0d",
						rsp_ch.payload.visible, rsp_ch.payload.culling_plane);
					fail_count++;
				end else begin
					rsp_t e;
					e = expected_verdicts.pop_front();
					if (e.visible !== rsp_ch.payload.visible) begin
						$error("visible: expected %0b, got %0b", e.visible,
							rsp_ch.payload.visible);
						fail_count++;
					end
					if (e.culling_plane !== rsp_ch.payload.culling_plane) begin
						$error("culling_plane: expected %0d, got %0d",
							e.culling_plane, rsp_ch.payload.culling_plane);
						fail_count++;
					end
				end
				rsp_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_wait > 0) begin
				rsp_wait--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else if (arst_n && !stim_done)
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= StallLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic q_t rand_q();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return q_t'($urandom);
			// small values within plus or minus three keep the planes meaningful
			default: return q_t'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
		endcase
	endfunction

	// a camera set-up: random view and projection rows, then a build
	task automatic queue_camera();
		for (int r = 0; r < 4; r++)
			pending_reqs.push_back(make_req(KIND_VIEW, 2'(r), rand_q(), rand_q(),
				rand_q(), rand_q()));
		for (int r = 0; r < 4; r++)
			pending_reqs.push_back(make_req(KIND_PROJ, 2'(r), rand_q(), rand_q(),
				rand_q(), rand_q()));
		pending_reqs.push_back(make_req(KIND_BUILD, 2'($urandom), rand_q(), rand_q(),
			rand_q(), rand_q()));
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_verdicts.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		stim_done = 0;
		idle_cycles = 0;
		hold_off_cycles = 0;
		for (int i = 0; i < 16; i++) begin
			view_m[i] = '0;
			proj_m[i] = '0;
		end
		for (int i = 0; i < 24; i++)
			planes[i] = '0;

		// tests before any build: all-zero planes, radius sign decides
		pending_reqs.push_back(make_req(KIND_POINT, 0, 32'sh7fffffff, 32'sh80000000, 0,
			32'sh80000000));
		pending_reqs.push_back(make_req(KIND_SPHERE, 3, 0, 0, 0, 32'sh80000000));
		pending_reqs.push_back(make_req(KIND_SPHERE, 1, 0, 0, 0, 32'sh7fffffff));
		pending_reqs.push_back(make_req(KIND_SPHERE, 2, 0, 0, 0, -1));
		// unused kinds are ignored
		for (int k = 5; k < 8; k++)
			pending_reqs.push_back(make_req(3'(k), 2'(k), -1, -1, -1, -1));
		// identity view, identity projection: planes w+-x etc.
		for (int r = 0; r < 4; r++) begin
			q_t e[4];
			for (int c = 0; c < 4; c++)
				e[c] = (r == c) ? 32'sh00010000 : 0;
			pending_reqs.push_back(make_req(KIND_VIEW, 2'(r), e[0], e[1], e[2], e[3]));
			pending_reqs.push_back(make_req(KIND_PROJ, 2'(r), e[0], e[1], e[2], e[3]));
		end
		pending_reqs.push_back(make_req(KIND_BUILD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 0, 0, 32'sh00008000, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 32'sh00020000, 0, 0, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 32'shfffe0000, 0, 0, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 0, 32'sh00020000, 0, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 0, 32'shfffe0000, 0, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 0, 0, 32'shffff0000, 0));
		pending_reqs.push_back(make_req(KIND_POINT, 0, 0, 0, 32'sh00020000, 0));
		// saturating extremes in the matrices
		for (int r = 0; r < 4; r++) begin
			pending_reqs.push_back(make_req(KIND_VIEW, 2'(r), 32'sh7fffffff,
				32'sh80000000, 32'sh7fffffff, 32'sh80000000));
			pending_reqs.push_back(make_req(KIND_PROJ, 2'(r), 32'sh80000000,
				32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
		end
		pending_reqs.push_back(make_req(KIND_BUILD, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(KIND_SPHERE, 0, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff));
		wait_drained();

		// back-pressure: receiver stalls long while tests keep coming
		hold_off_cycles = 300;
		for (int i = 0; i < 20; i++)
			pending_reqs.push_back(make_req(KIND_SPHERE, 0, rand_q(), rand_q(), rand_q(),
				rand_q()));

		// random: mostly a camera set-up followed by a batch of tests
		while (pending_reqs.size() + 60 < 1950 && $urandom_range(0, 1) >= 0) begin
			int n;
			if (pending_reqs.size() > 1900)
				break;
			if ($urandom_range(0, 9) == 0) begin
				pending_reqs.push_back(make_req(3'($urandom), 2'($urandom), q_t'($urandom),
					q_t'($urandom), q_t'($urandom), q_t'($urandom)));
				continue;
			end
			queue_camera();
			n = $urandom_range(5, 30);
			for (int i = 0; i < n; i++)
				pending_reqs.push_back(make_req($urandom_range(0, 1) ? KIND_POINT
					: KIND_SPHERE, 2'($urandom), rand_q(), rand_q(), rand_q(), rand_q()));
		end
		wait_drained();
		repeat (40) @(posedge clk);
		stim_done = 1;
		if (fail_count == 0 && expected_verdicts.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
